// ===== rtl/core/ssrg_pkg.sv =====
// Shared types and constants for the sensor smoothing and report gate.
package ssrg_pkg;

  // Fixed field widths
  localparam int RAW_W    = 16;
  localparam int TOTAL_W  = 16;
  localparam int CYCLE_W  = 8;
  localparam int SENSOR_W = 4;
  localparam int TENTHS_W = 12;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Item function codes
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_PUBLISH = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SENSOR_COUNT    = 2'd0;
  localparam logic [1:0] REG_MAX_INTERVAL    = 2'd1;
  localparam logic [1:0] REG_MIN_INTERVAL    = 2'd2;
  localparam logic [1:0] REG_DISCONNECT_CODE = 2'd3;

  // Tenths conversion: floor((total*10 + 64) / 128), saturated
  localparam int TENTHS_MULT  = 10;
  localparam int TENTHS_BIAS  = 64;
  localparam int TENTHS_SHIFT = 7;
  localparam logic signed [TENTHS_W-1:0] TENTHS_MAX = 12'sd2047;
  localparam logic signed [TENTHS_W-1:0] TENTHS_MIN = -12'sd2048;

  // Result queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

  typedef struct packed {
    logic                       func;
    logic [SENSOR_W-1:0]        sensor;
    logic signed [RAW_W-1:0]    raw_temp;
    logic [CYCLE_W-1:0]         now_cycle;
  } req_t;

  typedef struct packed {
    logic [SENSOR_W-1:0]        sensor_id;
    logic signed [TENTHS_W-1:0] tenths_c;
    logic                       is_offline;
  } rsp_t;

  typedef struct packed {
    logic [4:0]                 sensor_count;
    logic [6:0]                 max_interval;
    logic [7:0]                 min_interval;
    logic signed [RAW_W-1:0]    disconnect_code;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    sensor_count:    5'd16,
    max_interval:    7'd60,
    min_interval:    8'd29,
    disconnect_code: -16'sd7040
  };

  // Item as it sits in the update stage
  typedef struct packed {
    logic                       func;
    logic [SENSOR_W-1:0]        sensor;
    logic [CYCLE_W-1:0]         now_cycle;
    logic                       is_disc;
  } item_t;

  // Per-sensor bookkeeping word
  typedef struct packed {
    logic signed [TOTAL_W-1:0]  total;
    logic signed [TOTAL_W-1:0]  last_total;
    logic [CYCLE_W-1:0]         report_cycle;
    logic                       offline;
  } state_t;

  localparam state_t STATE_RST = '{
    total:        -16'sd7040,
    last_total:   16'sd0,
    report_cycle: 8'd0,
    offline:      1'b1
  };

endpackage

// ===== rtl/core/ssrg_stream_if.sv =====
// Valid/ready stream channel carrying one word per handshake.
interface ssrg_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sensor_smoothing_report_gate_core.sv =====
// Top level of the per-sensor smoothing and report gate.
//
//   port     role     word
//   req      sink     func, sensor, raw_temp, now_cycle
//   rsp      source   sensor_id, tenths_c, is_offline
//   apb      slave    4 registers at byte address 4*i
//
// One item per cycle while req.ready is high. Acceptance scales the reading
// and reads the sensor's bookkeeping RAM and ring RAM; next cycle updates and
// writes back, with a forwarding register for back-to-back items on one sensor.
// A report goes through the result queue before it is taken. req.ready drops
// only when the three-entry result queue plus the item in flight would fill it.
// After reset, per-sensor valid bits make state read as its reset values.
module sensor_smoothing_report_gate_core
  import ssrg_pkg::*;
#(
  parameter int SENSORS = 16,
  parameter int SAMPLES = 4
) (
  input  logic              clk,
  input  logic              rst,
  ssrg_stream_if.sink       req,
  ssrg_stream_if.source     rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int SA_W        = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SMP_W       = 17 - $clog2(SAMPLES + 1);
  localparam int SLOT_W      = $clog2(SAMPLES);
  localparam int ROW_W       = SLOT_W + SAMPLES * SMP_W;
  localparam int ST_W        = $bits(state_t);
  localparam int MAG_W       = RAW_W + 1;
  localparam int RECIP_SHIFT = MAG_W + $clog2(SAMPLES);
  localparam int RECIP       = (2**RECIP_SHIFT + SAMPLES - 1) / SAMPLES;
  localparam int RECIP_W     = MAG_W + 2;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int POS_LIM     = 32767 / SAMPLES;
  localparam int NEG_LIM     = 32768 / SAMPLES;

  cfg_t                    cfg;
  logic                    accept;

  // accept-stage scaling
  logic signed [MAG_W-1:0] raw_ext;
  logic                    raw_neg;
  logic [MAG_W-1:0]        raw_mag;
  logic [MAG_W-1:0]        num;
  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        qmag;
  logic [MAG_W-1:0]        qlim;
  logic [MAG_W-1:0]        qmag_c;
  logic signed [SMP_W-1:0] q_in;

  // update stage
  logic                    s1_valid;
  item_t                   s1_item;
  logic [SA_W-1:0]         s1_addr;
  logic                    s1_in_range;
  logic signed [SMP_W-1:0] s1_q;

  logic [ST_W-1:0]         st_rdata;
  logic [ROW_W-1:0]        ring_rdata;
  logic [SENSORS-1:0]      valid_bits;
  logic                    fwd_valid;
  logic [SA_W-1:0]         fwd_addr;
  state_t                  fwd_state;
  logic [ROW_W-1:0]        fwd_ring;
  logic                    hit;
  state_t                  state_cur;
  logic [ROW_W-1:0]        ring_cur;
  state_t                  state_next;
  logic [ROW_W-1:0]        ring_next;
  logic                    emit;
  rsp_t                    word;
  logic                    we;
  logic [OUTQ_CNT_W-1:0]   q_count;

  ssrg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Room for the item in flight and the new one in the result queue
  assign req.ready = ((OUTQ_CNT_W+1)'(q_count) + (OUTQ_CNT_W+1)'(s1_valid)) <
                     (OUTQ_CNT_W+1)'(OUTQ_DEPTH);
  assign accept = req.valid & req.ready;

  // Divide by SAMPLES, round half away from zero, clamp
  assign raw_ext = MAG_W'(req.payload.raw_temp);
  assign raw_neg = req.payload.raw_temp[RAW_W-1];
  assign raw_mag = raw_neg ? MAG_W'(-raw_ext) : MAG_W'(raw_ext);
  assign num     = raw_mag + MAG_W'(SAMPLES / 2);
  assign prod    = PROD_W'(num) * PROD_W'(RECIP);
  assign qmag    = prod[RECIP_SHIFT +: MAG_W];
  assign qlim    = raw_neg ? MAG_W'(NEG_LIM) : MAG_W'(POS_LIM);
  assign qmag_c  = (qmag > qlim) ? qlim : qmag;
  assign q_in    = raw_neg ? SMP_W'(-qmag_c) : SMP_W'(qmag_c);

  // Stage register, control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Stage register, payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.func      <= req.payload.func;
      s1_item.sensor    <= req.payload.sensor;
      s1_item.now_cycle <= req.payload.now_cycle;
      s1_item.is_disc   <= (req.payload.raw_temp == cfg.disconnect_code);
      s1_addr           <= SA_W'(req.payload.sensor);
      s1_in_range       <= (5'(req.payload.sensor) < cfg.sensor_count) &&
                           (32'(req.payload.sensor) < SENSORS);
      s1_q              <= q_in;
    end
  end

  ssrg_ram #(
    .WIDTH (ST_W),
    .DEPTH (SENSORS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (state_next),
    .raddr (SA_W'(req.payload.sensor)),
    .rdata (st_rdata)
  );

  ssrg_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SENSORS)
  ) u_ring_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (ring_next),
    .raddr (SA_W'(req.payload.sensor)),
    .rdata (ring_rdata)
  );

  // Forward last cycle's write; unwritten sensors read reset state
  assign hit = fwd_valid && (fwd_addr == s1_addr);

  always_comb begin
    if (hit) begin
      state_cur = fwd_state;
      ring_cur  = fwd_ring;
    end else begin
      state_cur = valid_bits[s1_addr] ? state_t'(st_rdata) : STATE_RST;
      ring_cur  = ring_rdata;
    end
  end

  ssrg_update #(
    .SAMPLES (SAMPLES)
  ) u_update (
    .cfg        (cfg),
    .item       (s1_item),
    .q          (s1_q),
    .state_cur  (state_cur),
    .ring_cur   (ring_cur),
    .state_next (state_next),
    .ring_next  (ring_next),
    .emit       (emit),
    .word       (word)
  );

  assign we = s1_valid && s1_in_range;

  // Written-once marks and forwarding control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      fwd_valid  <= 1'b0;
    end else begin
      fwd_valid <= we;
      if (we) begin
        valid_bits[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr  <= s1_addr;
    fwd_state <= state_next;
    fwd_ring  <= ring_next;
  end

  ssrg_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (we && emit),
    .push_word (word),
    .count     (q_count),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/core/ssrg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssrg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ssrg_regs.sv =====
// APB configuration registers.
module ssrg_regs
  import ssrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] reg_sel;
  logic       wr;

  assign reg_sel = paddr[APB_AW-1:2];
  assign wr      = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes, upper data bits dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (wr) begin
      unique case (reg_sel)
        REG_SENSOR_COUNT:    cfg.sensor_count    <= pwdata[4:0];
        REG_MAX_INTERVAL:    cfg.max_interval    <= pwdata[6:0];
        REG_MIN_INTERVAL:    cfg.min_interval    <= pwdata[7:0];
        REG_DISCONNECT_CODE: cfg.disconnect_code <= pwdata[RAW_W-1:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_SENSOR_COUNT:    prdata = APB_DW'(cfg.sensor_count);
      REG_MAX_INTERVAL:    prdata = APB_DW'(cfg.max_interval);
      REG_MIN_INTERVAL:    prdata = APB_DW'(cfg.min_interval);
      REG_DISCONNECT_CODE: prdata = APB_DW'(cfg.disconnect_code);
    endcase
  end

endmodule

// ===== rtl/core/ssrg_update.sv =====
// Read-modify-write datapath: ring and total update, report decision.
module ssrg_update
  import ssrg_pkg::*;
#(
  parameter int SAMPLES = 4
) (
  input  cfg_t                                   cfg,
  input  item_t                                  item,
  input  logic signed [17-$clog2(SAMPLES+1)-1:0] q,
  input  state_t                                 state_cur,
  input  logic [$clog2(SAMPLES)+SAMPLES*(17-$clog2(SAMPLES+1))-1:0] ring_cur,
  output state_t                                 state_next,
  output logic [$clog2(SAMPLES)+SAMPLES*(17-$clog2(SAMPLES+1))-1:0] ring_next,
  output logic                                   emit,
  output rsp_t                                   word
);

  localparam int SMP_W  = 17 - $clog2(SAMPLES + 1);
  localparam int SLOT_W = $clog2(SAMPLES);
  localparam int V_W    = TOTAL_W + 5;
  localparam int T_W    = V_W - TENTHS_SHIFT;

  logic [SLOT_W-1:0]           slot;
  logic [SLOT_W-1:0]           slot_inc;
  logic signed [SMP_W-1:0]     old_smp;
  logic signed [TOTAL_W-1:0]   total_upd;
  logic signed [TOTAL_W-1:0]   fill_total;
  logic [SAMPLES*SMP_W-1:0]    fill_row;
  logic [CYCLE_W-1:0]          elapsed;
  logic                        report;
  logic signed [V_W-1:0]       v;
  logic signed [T_W-1:0]       t;

  // Ring row: oldest slot in the low bits, samples above
  assign slot     = ring_cur[SLOT_W-1:0];
  assign old_smp  = ring_cur[SLOT_W + slot*SMP_W +: SMP_W];
  assign slot_inc = (slot == SLOT_W'(SAMPLES - 1)) ? '0 : slot + 1'b1;
  assign total_upd = state_cur.total - TOTAL_W'(old_smp) + TOTAL_W'(q);
  assign fill_total = TOTAL_W'(TOTAL_W'(q) * TOTAL_W'(SAMPLES));
  assign fill_row   = {SAMPLES{q}};

  // Report gate on the wrapping cycle count
  assign elapsed = item.now_cycle - state_cur.report_cycle;
  assign report  = (elapsed >= CYCLE_W'(cfg.max_interval)) ||
                   ((elapsed >= cfg.min_interval) &&
                    (state_cur.total != state_cur.last_total));

  // Tenths of a degree, floor division by 128
  assign v = V_W'(state_cur.total) * V_W'(TENTHS_MULT) + V_W'(TENTHS_BIAS);
  assign t = T_W'(v >>> TENTHS_SHIFT);

  always_comb begin
    word.sensor_id  = item.sensor;
    word.is_offline = state_cur.offline;
    if (t > T_W'(TENTHS_MAX)) begin
      word.tenths_c = TENTHS_MAX;
    end else if (t < T_W'(TENTHS_MIN)) begin
      word.tenths_c = TENTHS_MIN;
    end else begin
      word.tenths_c = TENTHS_W'(t);
    end
  end

  // Next state per item kind
  always_comb begin
    state_next = state_cur;
    ring_next  = ring_cur;
    emit       = 1'b0;
    if (item.func == FUNC_SAMPLE) begin
      if (item.is_disc) begin
        if (!state_cur.offline) begin
          state_next.offline       = 1'b1;
          state_next.total         = cfg.disconnect_code;
          ring_next[SLOT_W-1:0]    = '0;
        end
      end else if (state_cur.offline) begin
        // first good reading fills the whole ring
        ring_next          = {fill_row, SLOT_W'(0)};
        state_next.total   = fill_total;
        state_next.offline = 1'b0;
      end else begin
        ring_next[SLOT_W + slot*SMP_W +: SMP_W] = q;
        ring_next[SLOT_W-1:0]                  = slot_inc;
        state_next.total                       = total_upd;
      end
    end else if (report) begin
      state_next.last_total   = state_cur.total;
      state_next.report_cycle = item.now_cycle;
      emit                    = 1'b1;
    end
  end

endmodule

// ===== rtl/core/ssrg_outq.sv =====
// Small result queue in front of the output channel.
module ssrg_outq
  import ssrg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rsp_t                  push_word,
  output logic [OUTQ_CNT_W-1:0] count,
  ssrg_stream_if.source         rsp
);

  rsp_t                  entry [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] head;
  logic [OUTQ_PTR_W-1:0] tail;
  logic [OUTQ_PTR_W:0]   tail_sum;
  logic                  pop;

  assign pop         = rsp.valid & rsp.ready;
  assign rsp.valid   = (count != '0);
  assign rsp.payload = entry[head];

  // tail = head + count, wrapped
  assign tail_sum = (OUTQ_PTR_W+1)'(head) + (OUTQ_PTR_W+1)'(count);
  assign tail = (tail_sum >= (OUTQ_PTR_W+1)'(OUTQ_DEPTH)) ?
                OUTQ_PTR_W'(tail_sum - (OUTQ_PTR_W+1)'(OUTQ_DEPTH)) :
                OUTQ_PTR_W'(tail_sum);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_word;
    end
  end

  // Pointer and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= (head == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
    end
  end

endmodule

// ===== test/sensor_smoothing_report_gate_core_test.sv =====
// Self-checking testbench for the sensor smoothing and report gate core.
module sensor_smoothing_report_gate_core_test;
  import ssrg_pkg::*;

  localparam int SENSORS        = 16;
  localparam int SAMPLES        = 4;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 16;
  localparam int MISMATCH_SHOW  = 10;
  localparam int RANDOM_WORDS   = 105;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ssrg_stream_if #(.word_t(req_t)) req_ch ();
  ssrg_stream_if #(.word_t(rsp_t)) rsp_ch ();

  sensor_smoothing_report_gate_core #(
    .SENSORS(SENSORS),
    .SAMPLES(SAMPLES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predicted per-sensor state and register copy
  cfg_t                     cfg;
  logic signed [13:0]       ring_slots [SENSORS][SAMPLES];
  logic signed [TOTAL_W-1:0] sum_total [SENSORS];
  logic signed [TOTAL_W-1:0] last_total [SENSORS];
  logic [1:0]               next_slot [SENSORS];
  logic [CYCLE_W-1:0]       report_cycle [SENSORS];
  logic                     offline [SENSORS];

  rsp_t               pending_reports [$];
  int                 send_pct;
  int                 stall_pct;
  int                 mismatches;
  int                 words_sent;
  int                 reports_seen;
  int                 config_sets;
  logic [CYCLE_W-1:0] now_clock;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Update the predicted state for one accepted word; queue a report if due
  function automatic void smooth_and_gate(input req_t it);
    int                 s;
    int                 raw;
    int                 mag;
    int                 q;
    int                 v;
    int                 t;
    int                 k;
    logic [CYCLE_W-1:0] elapsed;
    rsp_t               rpt;
    s = int'(it.sensor);
    if (it.sensor >= cfg.sensor_count) return;
    if (it.func == FUNC_SAMPLE) begin
      if (it.raw_temp == cfg.disconnect_code) begin
        // disconnect only changes a sensor that is online
        if (!offline[s]) begin
          offline[s]   = 1'b1;
          sum_total[s] = cfg.disconnect_code;
          next_slot[s] = '0;
        end
      end else begin
        // divide by the tap count, half away from zero, then clamp
        raw = int'(it.raw_temp);
        mag = (raw < 0) ? -raw : raw;
        q = (mag + SAMPLES / 2) / SAMPLES;
        if (raw < 0) q = -q;
        if (q > 32767 / SAMPLES) q = 32767 / SAMPLES;
        if (q < -32768 / SAMPLES) q = -32768 / SAMPLES;
        if (offline[s]) begin
          // first good reading fills the whole ring
          for (k = 0; k < SAMPLES; k++) ring_slots[s][k] = q[13:0];
          sum_total[s] = TOTAL_W'(q * SAMPLES);
          next_slot[s] = '0;
          offline[s]   = 1'b0;
        end else begin
          sum_total[s] = TOTAL_W'(sum_total[s] - ring_slots[s][next_slot[s]] + q);
          ring_slots[s][next_slot[s]] = q[13:0];
          next_slot[s] = next_slot[s] + 1'b1;
        end
      end
      return;
    end
    // publish: max interval forces a report, min interval gates a change
    elapsed = it.now_cycle - report_cycle[s];
    if (elapsed < cfg.max_interval &&
        (elapsed < cfg.min_interval || sum_total[s] == last_total[s])) return;
    v = sum_total[s] * TENTHS_MULT + TENTHS_BIAS;
    t = v >>> TENTHS_SHIFT;
    if (t > TENTHS_MAX) t = int'(TENTHS_MAX);
    if (t < TENTHS_MIN) t = int'(TENTHS_MIN);
    rpt.sensor_id  = it.sensor;
    rpt.tenths_c   = t[TENTHS_W-1:0];
    rpt.is_offline = offline[s];
    pending_reports.push_back(rpt);
    last_total[s]   = sum_total[s];
    report_cycle[s] = it.now_cycle;
  endfunction

  // Mostly well-formed traffic: plausible readings and a slowly advancing clock
  function automatic req_t random_word();
    req_t it;
    int   pick;
    int   v;
    pick = $urandom_range(99);
    if (cfg.sensor_count == 0 || $urandom_range(9) == 0) begin
      it.sensor = SENSOR_W'($urandom_range(15));
    end else begin
      it.sensor = SENSOR_W'($urandom_range(cfg.sensor_count - 1));
    end
    it.raw_temp  = RAW_W'($urandom);
    it.now_cycle = CYCLE_W'($urandom);
    if (pick < 45) begin
      it.func = FUNC_SAMPLE;
      if (pick < 8) v = $urandom_range(16) - 8;
      else v = $urandom_range(12800) - 2560;
      it.raw_temp = v[RAW_W-1:0];
    end else if (pick < 50) begin
      it.func     = FUNC_SAMPLE;
      it.raw_temp = cfg.disconnect_code;
    end else if (pick < 55) begin
      it.func = FUNC_SAMPLE;
    end else begin
      it.func = FUNC_PUBLISH;
      if ($urandom_range(19) != 0) begin
        now_clock    = now_clock + CYCLE_W'($urandom_range(14));
        it.now_cycle = now_clock;
      end
    end
    return it;
  endfunction

  // Offer one word and hold it until accepted, then maybe go idle
  task automatic send_word(input req_t it);
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    smooth_and_gate(it);
    words_sent++;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
  endtask

  task automatic send_sample(input int s, input int raw);
    req_t it;
    it.func      = FUNC_SAMPLE;
    it.sensor    = s[SENSOR_W-1:0];
    it.raw_temp  = raw[RAW_W-1:0];
    it.now_cycle = CYCLE_W'($urandom);
    send_word(it);
  endtask

  task automatic send_publish(input int s, input int now);
    req_t it;
    it.func      = FUNC_PUBLISH;
    it.sensor    = s[SENSOR_W-1:0];
    it.raw_temp  = RAW_W'($urandom);
    it.now_cycle = now[CYCLE_W-1:0];
    send_word(it);
  endtask

  // Stop sending and wait for every owed report, plus a settle time
  task automatic drain_reports(input int settle);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle; psel is lowered by the caller
  task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    drain_reports(SETTLE_CYCLES);
    write_reg(REG_SENSOR_COUNT, APB_DW'(c.sensor_count));
    write_reg(REG_MAX_INTERVAL, APB_DW'(c.max_interval));
    write_reg(REG_MIN_INTERVAL, APB_DW'(c.min_interval));
    write_reg(REG_DISCONNECT_CODE, APB_DW'(c.disconnect_code));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg = c;
    config_sets++;
    @(posedge clk);
  endtask

  // Rounding, clamping at both rails, ring fill on first good reading
  task automatic test_rounding_and_fill();
    send_publish(0, 0);
    send_publish(0, 29);
    send_sample(0, 32767);
    send_publish(0, 58);
    send_sample(1, -32768);
    send_publish(1, 60);
    send_sample(2, 2);
    send_sample(2, -2);
    send_sample(2, 1);
    send_sample(2, -1);
    send_sample(2, 6);
    send_publish(2, 100);
  endtask

  // Min and max interval gating, including cycle wrap
  task automatic test_report_gate_timing();
    send_sample(3, 2560);
    send_publish(3, 200);
    send_publish(3, 201);
    send_sample(3, 2564);
    send_publish(3, 228);
    send_publish(3, 229);
    send_publish(3, 33);
    send_sample(15, -129);
    send_publish(15, 255);
    send_publish(15, 10);
  endtask

  // Disconnect on an online sensor, repeated disconnect, then recovery
  task automatic test_disconnect();
    send_sample(0, -7040);
    send_sample(0, -7040);
    send_publish(0, 140);
    send_sample(0, 128);
    send_publish(0, 172);
  endtask

  // Indices at or above sensor_count are ignored, down to a count of zero
  task automatic test_sensor_limit();
    cfg_t setting;
    setting = CFG_RST;
    setting.sensor_count = 5'd4;
    apply_config(setting);
    send_sample(5, 1000);
    send_publish(5, 250);
    send_publish(3, 250);
    setting.sensor_count = 5'd0;
    apply_config(setting);
    send_publish(0, 100);
    send_sample(1, 0);
    setting.sensor_count = 5'd1;
    apply_config(setting);
    send_publish(1, 99);
    send_publish(0, 99);
  endtask

  // Register sweep paired with the idle mixes, two settings per mix
  task automatic test_random_traffic();
    cfg_t setting;
    int   i;
    int   n;
    for (i = 0; i < 8; i++) begin
      setting = CFG_RST;
      case (i % 4)
        1: setting = '{5'd16, 7'd30, 8'd0, 16'sh8000};
        2: setting = '{5'd16, 7'd90, 8'd255, 16'sh7FFF};
        3: setting = '{5'd12, 7'd45, 8'd10, 16'sh0000};
        default: ;
      endcase
      apply_config(setting);
      case (i / 2)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 61; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 61; end
        default: begin send_pct = 33; stall_pct = 33; end
      endcase
      for (n = 0; n < RANDOM_WORDS; n++) begin
        // hold off the sender once per pass until every owed report has arrived
        if (n == RANDOM_WORDS / 2) drain_reports(0);
        send_word(random_word());
      end
    end
  endtask

  // Report checker and receiver ready pattern
  always @(posedge clk) begin : report_check
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        if (mismatches < MISMATCH_SHOW)
          $display("unexpected report: id=%0d tenths=%0d offline=%0d",
                   got.sensor_id, got.tenths_c, got.is_offline);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (got.sensor_id !== want.sensor_id || got.tenths_c !== want.tenths_c ||
            got.is_offline !== want.is_offline) begin
          if (mismatches < MISMATCH_SHOW)
            $display({"report mismatch: exp id=%0d tenths=%0d offline=%0d,",
                      " got id=%0d tenths=%0d offline=%0d"},
                     want.sensor_id, want.tenths_c, want.is_offline,
                     got.sensor_id, got.tenths_c, got.is_offline);
          mismatches++;
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any word moving ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (psel && penable && pwrite))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no traffic for %0d cycles, %0d reports owed",
             QUIET_LIMIT, pending_reports.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_flow
    int s;
    int k;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_pct       = 0;
    stall_pct      = 0;
    mismatches     = 0;
    words_sent     = 0;
    reports_seen   = 0;
    config_sets    = 0;
    now_clock      = '0;
    cfg            = CFG_RST;
    for (s = 0; s < SENSORS; s++) begin
      for (k = 0; k < SAMPLES; k++) ring_slots[s][k] = '0;
      sum_total[s]    = STATE_RST.total;
      last_total[s]   = STATE_RST.last_total;
      next_slot[s]    = '0;
      report_cycle[s] = STATE_RST.report_cycle;
      offline[s]      = STATE_RST.offline;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rounding_and_fill();
    test_report_gate_timing();
    test_disconnect();
    test_sensor_limit();
    test_random_traffic();
    drain_reports(TAIL_CYCLES);

    $display("Covered %0d input words and %0d checked reports over %0d register settings,",
             words_sent, reports_seen, config_sets);
    $display("with all four sender/receiver idle mixes; mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ssrg_pkg.sv
rtl/core/ssrg_stream_if.sv
rtl/core/ssrg_ram.sv
rtl/core/ssrg_regs.sv
rtl/core/ssrg_update.sv
rtl/core/ssrg_outq.sv
rtl/core/sensor_smoothing_report_gate_core.sv
test/sensor_smoothing_report_gate_core_test.sv
